>>> hdl/pba_pkg.sv
package pba_pkg;

	localparam int NUM_PAGES_D  = 1024;
	localparam int PAGE_SHIFT_D = 12;

	localparam int WORD_W  = 32;
	localparam int WORD_SH = 5;

	localparam int ADDR_W    = 32;
	localparam int OUT_IDX_W = 10;
	localparam int REQ_W     = 2;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_INIT  = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_PAGE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MEM_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEM_END    = 2'd2;

	localparam logic [ADDR_W-1:0] MEM_BASE_RST   = 32'h8000_0000;
	localparam logic [ADDR_W-1:0] KERNEL_END_RST = 32'h8000_0000;
	localparam logic [ADDR_W-1:0] MEM_END_RST    = 32'h8040_0000;

	localparam int BOUND_LAT = 3;

endpackage

>>> hdl/page_bitmap_allocator_core.sv
// First-fit page allocator over a one-bit-per-page free map held in a synchronous
// RAM of 32-bit words, one result word per request word. After reset a clearing
// pass writes every map word (NUM_PAGES_P / 32, rounded up) to all used, while no
// request is taken. An allocate scans the map one word per cycle, and an init
// rewrites every map word. The result sits in an output register, so a new
// request is taken while the previous result still waits.
module page_bitmap_allocator_core import pba_pkg::*; #(
	parameter int NUM_PAGES_P = NUM_PAGES_D,
	parameter int PAGE_SHIFT  = PAGE_SHIFT_D
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,   // address
	input  logic [7:0]           s_tuser,   // req_type, zero fill
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [47:0]          m_tdata,   // page_address, page_index, zero fill
	output logic [7:0]           m_tuser,   // status, zero fill
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data
);

	localparam int NUM_WORDS = (NUM_PAGES_P + WORD_W - 1) / WORD_W;
	localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int IDX_W     = $clog2(NUM_PAGES_P);
	localparam int CNT_W     = $clog2(NUM_PAGES_P + 1);
	localparam logic [WIDX_W-1:0] LAST_W = WIDX_W'(NUM_WORDS - 1);
	localparam logic [ADDR_W-1:0] PG_MASK32 = 32'((64'd1 << PAGE_SHIFT) - 64'd1);

	typedef enum logic [7:0] {
		ST_CLEAR     = 8'b0000_0001,
		ST_IDLE      = 8'b0000_0010,
		ST_ALLOC     = 8'b0000_0100,
		ST_FREE_RD   = 8'b0000_1000,
		ST_FREE_WR   = 8'b0001_0000,
		ST_INIT_WAIT = 8'b0010_0000,
		ST_INIT      = 8'b0100_0000,
		ST_DONE      = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic [WIDX_W-1:0]   scan_q;
	logic                issue_done_q;
	logic                rd_vld_s1;
	logic [WIDX_W-1:0]   rd_widx_s1;
	logic [ADDR_W-1:0]   addr_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic [1:0]          wait_q;
	logic [ADDR_W-1:0]   pend_addr_q;
	logic [OUT_IDX_W-1:0] pend_idx_q;
	logic [STATUS_W-1:0] pend_st_q;
	logic                m_valid_q;
	logic [ADDR_W-1:0]   m_addr_q;
	logic [OUT_IDX_W-1:0] m_idx_q;
	logic [STATUS_W-1:0] m_st_q;
	logic [ADDR_W-1:0]   mem_base_q;
	logic [ADDR_W-1:0]   kernel_end_q;
	logic [ADDR_W-1:0]   mem_end_q;

	logic                rd_en;
	logic [WIDX_W-1:0]   rd_addr;
	logic [WORD_W-1:0]   rd_data;
	logic                wr_en;
	logic [WIDX_W-1:0]   wr_addr;
	logic [WORD_W-1:0]   wr_data;

	logic [CNT_W-1:0]    clr_hi;
	logic [CNT_W-1:0]    set_lo;
	logic [CNT_W-1:0]    set_hi;

	logic [ADDR_W-1:0]   fr_page;
	logic [ADDR_W-1:0]   fr_idx32;
	logic                fr_oor;
	logic [WIDX_W-1:0]   fr_widx;
	logic [WIDX_W-1:0]   fw_widx;
	logic [WORD_SH-1:0]  fw_bit;
	logic [WORD_SH-1:0]  ffs_bit;
	logic [ADDR_W-1:0]   alloc_idx32;
	logic [WORD_W-1:0]   clr_mask;
	logic [WORD_W-1:0]   set_mask;
	logic                accept;
	logic                res_load;

	function automatic logic [WORD_SH-1:0] first_set(input logic [WORD_W-1:0] w);
		logic [WORD_SH-1:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) begin
				r = WORD_SH'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] below_mask(input logic [CNT_W-1:0] bnd,
			input logic [WIDX_W-1:0] w);
		logic [31:0] b;
		logic [31:0] lo;
		logic [31:0] off;
		logic [WORD_W-1:0] r;
		b   = 32'(bnd);
		lo  = 32'(w) << WORD_SH;
		off = b - lo;
		if (b <= lo) begin
			r = '0;
		end else if (b >= lo + 32'(WORD_W)) begin
			r = '1;
		end else begin
			r = ~({WORD_W{1'b1}} << off[WORD_SH-1:0]);
		end
		return r;
	endfunction

	pba_map_ram #(
		.WORDS  (NUM_WORDS),
		.ADDR_W (WIDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pba_bound_calc #(
		.NUM_PAGES_P (NUM_PAGES_P),
		.PAGE_SHIFT  (PAGE_SHIFT),
		.CNT_W       (CNT_W)
	) u_bound (
		.clk        (clk),
		.arst_n     (arst_n),
		.mem_base   (mem_base_q),
		.kernel_end (kernel_end_q),
		.mem_end    (mem_end_q),
		.clr_hi     (clr_hi),
		.set_lo     (set_lo),
		.set_hi     (set_hi)
	);

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = {6'd0, m_idx_q, m_addr_q};
	assign m_tuser   = {6'd0, m_st_q};
	assign res_load  = (state_q == ST_DONE) && (!m_valid_q || m_tready);

	assign fr_page  = addr_q & ~PG_MASK32;
	assign fr_idx32 = (fr_page - mem_base_q) >> PAGE_SHIFT;
	assign fr_oor   = (fr_page < mem_base_q) || (fr_idx32 >= 32'(NUM_PAGES_P));
	assign fr_widx  = WIDX_W'(fr_idx32 >> WORD_SH);
	assign fw_widx  = WIDX_W'(32'(free_idx_q) >> WORD_SH);
	assign fw_bit   = WORD_SH'(32'(free_idx_q));

	assign ffs_bit     = first_set(rd_data);
	assign alloc_idx32 = (32'(rd_widx_s1) << WORD_SH) | 32'(ffs_bit);
	assign clr_mask    = below_mask(clr_hi, rd_widx_s1);
	assign set_mask    = below_mask(set_hi, rd_widx_s1) & ~below_mask(set_lo, rd_widx_s1);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = scan_q;
		wr_en   = 1'b0;
		wr_addr = rd_widx_s1;
		wr_data = '0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = scan_q;
			end
			ST_ALLOC: begin
				rd_en = !issue_done_q;
				if (rd_vld_s1 && (rd_data != '0)) begin
					wr_en   = 1'b1;
					wr_data = rd_data & ~(WORD_W'(1) << ffs_bit);
				end
			end
			ST_INIT: begin
				rd_en = !issue_done_q;
				if (rd_vld_s1) begin
					wr_en   = 1'b1;
					wr_data = (rd_data & ~clr_mask) | set_mask;
				end
			end
			ST_FREE_RD: begin
				rd_en   = !fr_oor;
				rd_addr = fr_widx;
			end
			ST_FREE_WR: begin
				wr_en   = 1'b1;
				wr_addr = fw_widx;
				wr_data = rd_data | (WORD_W'(1) << fw_bit);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_base_q   <= MEM_BASE_RST;
			kernel_end_q <= KERNEL_END_RST;
			mem_end_q    <= MEM_END_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MEM_BASE:   mem_base_q   <= cfg_data;
				CFG_KERNEL_END: kernel_end_q <= cfg_data;
				CFG_MEM_END:    mem_end_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			scan_q       <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			rd_widx_s1   <= '0;
			wait_q       <= '0;
		end else begin
			rd_vld_s1  <= rd_en;
			rd_widx_s1 <= rd_addr;
			if (rd_en && ((state_q == ST_ALLOC) || (state_q == ST_INIT))) begin
				scan_q <= scan_q + WIDX_W'(1);
				if (scan_q == LAST_W) begin
					issue_done_q <= 1'b1;
				end
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (scan_q == LAST_W) begin
						scan_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						scan_q <= scan_q + WIDX_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						scan_q       <= '0;
						issue_done_q <= 1'b0;
						wait_q       <= '0;
						unique case (s_tuser[REQ_W-1:0])
							REQ_ALLOC: state_q <= ST_ALLOC;
							REQ_FREE:  state_q <= ST_FREE_RD;
							REQ_INIT:  state_q <= ST_INIT_WAIT;
							default:   state_q <= ST_DONE;
						endcase
					end
				end
				ST_ALLOC: begin
					if (rd_vld_s1 && ((rd_data != '0) || (rd_widx_s1 == LAST_W))) begin
						state_q <= ST_DONE;
					end
				end
				ST_FREE_RD: begin
					state_q <= fr_oor ? ST_DONE : ST_FREE_WR;
				end
				ST_FREE_WR: begin
					state_q <= ST_DONE;
				end
				ST_INIT_WAIT: begin
					wait_q <= wait_q + 2'd1;
					if (wait_q == 2'(BOUND_LAT - 1)) begin
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					if (rd_vld_s1 && (rd_widx_s1 == LAST_W)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q      <= s_tdata;
			pend_addr_q <= '0;
			pend_idx_q  <= '0;
			pend_st_q   <= STATUS_OK;
		end
		if ((state_q == ST_ALLOC) && rd_vld_s1) begin
			if (rd_data != '0) begin
				pend_addr_q <= mem_base_q + (alloc_idx32 << PAGE_SHIFT);
				pend_idx_q  <= OUT_IDX_W'(alloc_idx32);
				pend_st_q   <= STATUS_OK;
			end else begin
				pend_st_q   <= STATUS_NO_PAGE;
			end
		end
		if (state_q == ST_FREE_RD) begin
			free_idx_q <= IDX_W'(fr_idx32);
			pend_st_q  <= fr_oor ? STATUS_RANGE : STATUS_OK;
		end
		if (state_q == ST_FREE_WR) begin
			pend_idx_q <= OUT_IDX_W'(32'(free_idx_q));
		end
		if (res_load) begin
			m_addr_q <= pend_addr_q;
			m_idx_q  <= pend_idx_q;
			m_st_q   <= pend_st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("map read and write hit the same word");

	a_alloc_one_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && (state_q == ST_ALLOC)) |-> ($countones(rd_data ^ wr_data) == 1))
		else $error("allocate changed other than one page");

	a_result_not_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("pending result lost");

	a_ok_alloc_addr: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_ALLOC) && rd_vld_s1 && (rd_data != '0)) |=>
		(pend_st_q == STATUS_OK) && (state_q == ST_DONE))
		else $error("allocate hit did not finish");

endmodule

>>> hdl/pba_map_ram.sv
module pba_map_ram import pba_pkg::*; #(
	parameter int WORDS  = NUM_PAGES_D / WORD_W,
	parameter int ADDR_W = 5
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WORD_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hdl/pba_bound_calc.sv
module pba_bound_calc import pba_pkg::*; #(
	parameter int NUM_PAGES_P = NUM_PAGES_D,
	parameter int PAGE_SHIFT  = PAGE_SHIFT_D,
	parameter int CNT_W       = $clog2(NUM_PAGES_P + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ADDR_W-1:0] mem_base,
	input  logic [ADDR_W-1:0] kernel_end,
	input  logic [ADDR_W-1:0] mem_end,
	output logic [CNT_W-1:0]  clr_hi,
	output logic [CNT_W-1:0]  set_lo,
	output logic [CNT_W-1:0]  set_hi
);

	localparam logic [32:0] PG_MASK = 33'((64'd1 << PAGE_SHIFT) - 64'd1);
	localparam logic signed [33:0] NUM_S = 34'(NUM_PAGES_P);

	logic [32:0]        start_s1;
	logic [ADDR_W-1:0]  base_s1;
	logic [ADDR_W-1:0]  end_s1;
	logic signed [33:0] d0_s2;
	logic               ge_s2;
	logic               set_en_s2;
	logic signed [33:0] cnt_s2;

	logic signed [33:0] diff;
	logic [32:0]        stop;
	logic [32:0]        span;
	logic signed [33:0] sum;

	function automatic logic [CNT_W-1:0] clamp(input logic signed [33:0] v);
		logic [CNT_W-1:0] r;
		if (v < 34'sd0) begin
			r = '0;
		end else if (v > NUM_S) begin
			r = CNT_W'(NUM_PAGES_P);
		end else begin
			r = CNT_W'(v);
		end
		return r;
	endfunction

	assign diff = $signed({1'b0, start_s1}) - $signed({2'b00, base_s1});
	assign stop = {1'b0, end_s1} & ~PG_MASK;
	assign span = (stop - start_s1 + PG_MASK) >> PAGE_SHIFT;
	assign sum  = d0_s2 + cnt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_s1  <= '0;
			base_s1   <= '0;
			end_s1    <= '0;
			d0_s2     <= '0;
			ge_s2     <= 1'b0;
			set_en_s2 <= 1'b0;
			cnt_s2    <= '0;
			clr_hi    <= '0;
			set_lo    <= '0;
			set_hi    <= '0;
		end else begin
			start_s1  <= ({1'b0, kernel_end} + PG_MASK) & ~PG_MASK;
			base_s1   <= mem_base;
			end_s1    <= mem_end;
			d0_s2     <= diff >>> PAGE_SHIFT;
			ge_s2     <= !diff[33];
			set_en_s2 <= start_s1 < {1'b0, end_s1};
			cnt_s2    <= (stop > start_s1) ? $signed({1'b0, span}) : 34'sd1;
			clr_hi    <= ge_s2 ? clamp(d0_s2) : '0;
			set_lo    <= clamp(d0_s2);
			set_hi    <= set_en_s2 ? clamp(sum) : '0;
		end
	end

endmodule
